// ===== rtl/core/cdd_pkg.sv =====
// ----------------------------------------------------------------------------
// cdd_pkg: shared types and tables for the calendar date difference block
// Field widths, day number widths, the reciprocal for the divide by 100
// and the month tables used by the day number pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cdd_pkg;

	// field widths
	localparam int unsigned YEAR_BITS  = 14;
	localparam int unsigned MONTH_BITS = 4;
	localparam int unsigned DAY_BITS   = 5;
	localparam int unsigned COUNT_BITS = 22;
	localparam int unsigned COUNT_MAX  = 4194303;

	// day number since 1 january of year 0 stays below 512 * 2^YEAR_BITS
	localparam int unsigned DN_BITS    = YEAR_BITS + 9;
	// year / 100 stays below 2^YEAR_BITS / 64
	localparam int unsigned Q100_BITS  = YEAR_BITS - 6;
	localparam int unsigned REM_BITS   = 8;
	// day within the year, up to 365
	localparam int unsigned MD_BITS    = 9;

	// year / 100 as a multiply by a truncated reciprocal, off by at most one
	localparam int unsigned DIV100_SHIFT = YEAR_BITS + 7;
	localparam int unsigned DIV100_MUL   = (1 << DIV100_SHIFT) / 100;
	localparam int unsigned MUL_BITS     = $clog2(DIV100_MUL + 1);
	localparam int unsigned PROD_BITS    = YEAR_BITS + MUL_BITS;

	// width for the count before saturation
	localparam int unsigned WIDE_BITS =
		((DN_BITS >= COUNT_BITS) ? DN_BITS : COUNT_BITS) + 1;

	localparam int unsigned MONTH_FEB = 2;
	localparam int unsigned DAYS_LEAP_FEB = 29;

	typedef logic [YEAR_BITS-1:0]  year_t;
	typedef logic [MONTH_BITS-1:0] month_t;
	typedef logic [DAY_BITS-1:0]   day_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [DN_BITS-1:0]    dn_t;
	typedef logic [Q100_BITS-1:0]  q100_t;
	typedef logic [REM_BITS-1:0]   rem_t;
	typedef logic [MD_BITS-1:0]    md_t;
	typedef logic [PROD_BITS-1:0]  prod_t;
	typedef logic [WIDE_BITS-1:0]  wide_t;

	// input word: one pair of dates
	typedef struct packed {
		year_t  first_year;
		month_t first_month;
		day_t   first_day;
		year_t  second_year;
		month_t second_month;
		day_t   second_day;
		logic   include_end_day;
	} date_pair_t;

	// output word
	typedef struct packed {
		count_t day_count;
		logic   invalid_date;
	} result_t;

	// load enables of the day number stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	// length of a month in a common year, zero for a month outside 1..12
	function automatic day_t month_len(input month_t m);
		day_t len;
		len = day_t'(0);
		if (m inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}) begin
			len = day_t'(31);
		end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
			len = day_t'(30);
		end else if (m == month_t'(MONTH_FEB)) begin
			len = day_t'(28);
		end
		return len;
	endfunction

	// days before the first of a month in a common year
	function automatic md_t month_start(input month_t m);
		md_t start;
		case (m)
			4'd1:    start = md_t'(0);
			4'd2:    start = md_t'(31);
			4'd3:    start = md_t'(59);
			4'd4:    start = md_t'(90);
			4'd5:    start = md_t'(120);
			4'd6:    start = md_t'(151);
			4'd7:    start = md_t'(181);
			4'd8:    start = md_t'(212);
			4'd9:    start = md_t'(243);
			4'd10:   start = md_t'(273);
			4'd11:   start = md_t'(304);
			4'd12:   start = md_t'(334);
			default: start = md_t'(0);
		endcase
		return start;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cdd_day_number.sv =====
// ----------------------------------------------------------------------------
// cdd_day_number: four stage day number pipeline for one date
// Turns year, month and day into days since 1 january of year 0 and checks
// that the date exists. Valid bits live in the caller, which drives the
// stage load enables.
// ----------------------------------------------------------------------------
`default_nettype none

module cdd_day_number (
	input  wire logic              clk,
	input  wire cdd_pkg::stage_en_t en,
	input  wire cdd_pkg::year_t    year,
	input  wire cdd_pkg::month_t   month,
	input  wire cdd_pkg::day_t     day,
	output cdd_pkg::dn_t           day_num,
	output logic                   date_ok
);

	// stage 1: reciprocal multiply for year / 100
	cdd_pkg::year_t  year_s1;
	cdd_pkg::month_t month_s1;
	cdd_pkg::day_t   day_s1;
	cdd_pkg::prod_t  prod_s1;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			year_s1  <= year;
			month_s1 <= month;
			day_s1   <= day;
			prod_s1  <= cdd_pkg::prod_t'(year) * cdd_pkg::prod_t'(cdd_pkg::DIV100_MUL);
		end
	end

	// stage 2: quotient estimate and one correction step
	cdd_pkg::prod_t prod_shift;
	cdd_pkg::q100_t q_est;
	cdd_pkg::year_t r_wide;
	cdd_pkg::rem_t  r_est;
	cdd_pkg::q100_t q_fix;
	cdd_pkg::rem_t  r_fix;

	always_comb begin
		prod_shift = prod_s1 >> cdd_pkg::DIV100_SHIFT;
		q_est      = prod_shift[cdd_pkg::Q100_BITS-1:0];
		r_wide     = year_s1 -
			cdd_pkg::year_t'(cdd_pkg::year_t'(q_est) * cdd_pkg::year_t'(100));
		r_est      = r_wide[cdd_pkg::REM_BITS-1:0];
		if (r_est >= cdd_pkg::rem_t'(100)) begin
			q_fix = q_est + cdd_pkg::q100_t'(1);
			r_fix = r_est - cdd_pkg::rem_t'(100);
		end else begin
			q_fix = q_est;
			r_fix = r_est;
		end
	end

	cdd_pkg::year_t  year_s2;
	cdd_pkg::month_t month_s2;
	cdd_pkg::day_t   day_s2;
	cdd_pkg::q100_t  q100_s2;
	logic            nz100_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			year_s2  <= year_s1;
			month_s2 <= month_s1;
			day_s2   <= day_s1;
			q100_s2  <= q_fix;
			nz100_s2 <= (r_fix != cdd_pkg::rem_t'(0));
		end
	end

	// stage 3: leap rule, year part, day within year, date check
	logic           leap;
	logic           nz400;
	cdd_pkg::dn_t   quad;
	cdd_pkg::dn_t   year_days;
	cdd_pkg::day_t  len;
	logic           ok;
	cdd_pkg::md_t   md;

	always_comb begin
		leap  = (year_s2[1:0] == 2'b00) && (nz100_s2 || (q100_s2[1:0] == 2'b00));
		nz400 = nz100_s2 || (q100_s2[1:0] != 2'b00);
		quad  = (cdd_pkg::dn_t'(year_s2) + cdd_pkg::dn_t'(3)) >> 2;
		year_days = cdd_pkg::dn_t'(year_s2) * cdd_pkg::dn_t'(365) + quad
			- cdd_pkg::dn_t'(q100_s2) - cdd_pkg::dn_t'(nz100_s2)
			+ cdd_pkg::dn_t'(q100_s2 >> 2) + cdd_pkg::dn_t'(nz400);
		if ((month_s2 == cdd_pkg::month_t'(cdd_pkg::MONTH_FEB)) && leap) begin
			len = cdd_pkg::day_t'(cdd_pkg::DAYS_LEAP_FEB);
		end else begin
			len = cdd_pkg::month_len(month_s2);
		end
		// a month outside 1..12 has length zero and fails here
		ok = (day_s2 != cdd_pkg::day_t'(0)) && (day_s2 <= len);
		md = cdd_pkg::month_start(month_s2)
			+ cdd_pkg::md_t'((month_s2 > cdd_pkg::month_t'(cdd_pkg::MONTH_FEB)) && leap)
			+ cdd_pkg::md_t'(day_s2) - cdd_pkg::md_t'(1);
	end

	cdd_pkg::dn_t year_days_s3;
	cdd_pkg::md_t md_s3;
	logic         ok_s3;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			year_days_s3 <= year_days;
			md_s3        <= md;
			ok_s3        <= ok;
		end
	end

	// stage 4: full day number
	always_ff @(posedge clk) begin
		if (en.s4) begin
			day_num <= year_days_s3 + cdd_pkg::dn_t'(md_s3);
			date_ok <= ok_s3;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/calendar_date_difference.sv =====
// ----------------------------------------------------------------------------
// calendar_date_difference: days between two gregorian dates
// Closed form day numbers for both dates, then the absolute difference,
// the optional end day and saturation to the count width.
//
//   channel  | valid       | stall       | word
//   ---------+-------------+-------------+------------------------------
//   dates in | date_valid  | date_stall  | date  (cdd_pkg::date_pair_t)
//   count out| count_valid | count_stall | count (cdd_pkg::result_t)
//
// one word per cycle sustained while count_stall stays low, six register stages,
// each word moving from s1 to s6 in order; the depth is set by the reciprocal multiply
// for year / 100 and the day number adder chain, each given its own stage
// arst_n clears the stage valid bits only, no clearing pass
// each full stage holds while the stage after it is full and not moving, so
// bubbles close up and date_stall rises only with every stage full
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_difference (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                date_valid,
	output logic                     date_stall,
	input  wire cdd_pkg::date_pair_t date,
	output logic                     count_valid,
	input  wire logic                count_stall,
	output cdd_pkg::result_t         count
);

	// stage valid bits and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	cdd_pkg::stage_en_t dn_en;

	always_comb begin
		en_s6 = !v_s6 || !count_stall;
		en_s5 = !v_s5 || en_s6;
		en_s4 = !v_s4 || en_s5;
		en_s3 = !v_s3 || en_s4;
		en_s2 = !v_s2 || en_s3;
		en_s1 = !v_s1 || en_s2;
		dn_en.s1 = en_s1;
		dn_en.s2 = en_s2;
		dn_en.s3 = en_s3;
		dn_en.s4 = en_s4;
	end

	assign date_stall  = !en_s1;
	assign count_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= date_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// day numbers of both dates
	cdd_pkg::dn_t first_dn, second_dn;
	logic         first_ok, second_ok;

	cdd_day_number u_first (
		.clk     (clk),
		.en      (dn_en),
		.year    (date.first_year),
		.month   (date.first_month),
		.day     (date.first_day),
		.day_num (first_dn),
		.date_ok (first_ok)
	);

	cdd_day_number u_second (
		.clk     (clk),
		.en      (dn_en),
		.year    (date.second_year),
		.month   (date.second_month),
		.day     (date.second_day),
		.day_num (second_dn),
		.date_ok (second_ok)
	);

	// end day flag rides along with the day number stages
	logic inc_s1, inc_s2, inc_s3, inc_s4;

	always_ff @(posedge clk) begin
		if (en_s1) inc_s1 <= date.include_end_day;
		if (en_s2) inc_s2 <= inc_s1;
		if (en_s3) inc_s3 <= inc_s2;
		if (en_s4) inc_s4 <= inc_s3;
	end

	// stage 5: absolute difference
	cdd_pkg::dn_t diff_s5;
	logic         inc_s5;
	logic         inv_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			diff_s5 <= (first_dn > second_dn) ? (first_dn - second_dn)
			                                  : (second_dn - first_dn);
			inc_s5  <= inc_s4;
			inv_s5  <= !(first_ok && second_ok);
		end
	end

	// stage 6: end day, saturation, zero on an impossible date
	cdd_pkg::wide_t total;

	assign total = cdd_pkg::wide_t'(diff_s5) + cdd_pkg::wide_t'(inc_s5);

	always_ff @(posedge clk) begin
		if (en_s6) begin
			count.invalid_date <= inv_s5;
			if (inv_s5) begin
				count.day_count <= cdd_pkg::count_t'(0);
			end else if (total > cdd_pkg::wide_t'(cdd_pkg::COUNT_MAX)) begin
				count.day_count <= cdd_pkg::count_t'(cdd_pkg::COUNT_MAX);
			end else begin
				count.day_count <= total[cdd_pkg::COUNT_BITS-1:0];
			end
		end
	end

	// checks

	// input back-pressure only with every stage occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		date_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6))
		else $error("date_stall raised while a stage is empty");

	// an impossible date always comes out with a zero count
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(count_valid && count.invalid_date) |-> (count.day_count == cdd_pkg::count_t'(0)))
		else $error("invalid date with nonzero count");

	// a valid pair with the end day counted never gives zero
	a_inc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(en_s6 && v_s5 && !inv_s5 && inc_s5) |=> (count.day_count != cdd_pkg::count_t'(0)))
		else $error("end day counted but count is zero");

	// a word that leaves stage 5 lands in the output register
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(en_s6 && v_s5) |=> count_valid)
		else $error("word lost between stage 5 and output");

endmodule

`default_nettype wire

// ===== test/cdd_span_check_pkg.sv =====
// ----------------------------------------------------------------------------
// cdd_span_check_pkg: expected day counts for the date difference block
// Holds the calendar tables and a small checker class that works out the
// count word for every accepted date pair, queues it and compares each
// count word leaving the block against the oldest queued one.
// ----------------------------------------------------------------------------
package cdd_span_check_pkg;

	import cdd_pkg::*;

	localparam int unsigned MONTHS_PER_YEAR = 12;

	// days before the first of each month, common year
	localparam int unsigned DAYS_BEFORE [MONTHS_PER_YEAR] =
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	// month lengths, common year
	localparam int unsigned COMMON_LEN [MONTHS_PER_YEAR] =
		'{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	class date_span_checker;

		result_t expected_spans[$];
		int      mismatches;

		function new();
			mismatches = 0;
		endfunction

		// 400/100/4 rule, year zero counts as leap
		static function bit leap_year(int unsigned y);
			return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
		endfunction

		// zero for a month outside the calendar
		static function int unsigned month_days(int unsigned y, int unsigned m);
			if (m < 1 || m > MONTHS_PER_YEAR) begin
				return 0;
			end
			if (m == MONTH_FEB && leap_year(y)) begin
				return DAYS_LEAP_FEB;
			end
			return COMMON_LEN[m-1];
		endfunction

		// days since 1 january of year 0
		static function int unsigned day_ordinal(int unsigned y, int unsigned m,
			int unsigned d);
			int unsigned n;
			n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
			n += DAYS_BEFORE[m-1] + d - 1;
			if (m > MONTH_FEB && leap_year(y)) begin
				n++;
			end
			return n;
		endfunction

		static function bit date_exists(int unsigned y, int unsigned m,
			int unsigned d);
			return d >= 1 && d <= month_days(y, m);
		endfunction

		// count word the block owes for one date pair
		static function result_t span_between(date_pair_t w);
			result_t     r;
			int unsigned a;
			int unsigned b;
			int unsigned diff;
			r = '0;
			if (!date_exists(w.first_year, w.first_month, w.first_day) ||
				!date_exists(w.second_year, w.second_month, w.second_day)) begin
				r.invalid_date = 1'b1;
				return r;
			end
			a = day_ordinal(w.first_year, w.first_month, w.first_day);
			b = day_ordinal(w.second_year, w.second_month, w.second_day);
			diff = (a > b) ? (a - b) : (b - a);
			diff += w.include_end_day;
			// saturate to the count width
			if (diff > COUNT_MAX) begin
				diff = COUNT_MAX;
			end
			r.day_count = count_t'(diff);
			return r;
		endfunction

		function void note_pair(date_pair_t w);
			expected_spans.push_back(span_between(w));
		endfunction

		function void check_count(result_t got);
			result_t want;
			if (expected_spans.size() == 0) begin
				$error("count word %0d/%0d with no date pair waiting",
					got.day_count, got.invalid_date);
				mismatches++;
				return;
			end
			want = expected_spans.pop_front();
			if (got.day_count !== want.day_count) begin
				$error("day_count: expected %0d, actual %0d",
					want.day_count, got.day_count);
				mismatches++;
			end
			if (got.invalid_date !== want.invalid_date) begin
				$error("invalid_date: expected %0d, actual %0d",
					want.invalid_date, got.invalid_date);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return expected_spans.size();
		endfunction

	endclass

endpackage

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the calendar date difference block
// Sends directed corner dates and then random date pairs through the input
// channel in random bursts while the output side stalls on its own pattern,
// and checks every count word against the expected day count.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import cdd_pkg::*;
	import cdd_span_check_pkg::*;

	localparam int CLK_PERIOD   = 2;
	localparam int RESET_CYCLES = 3;
	localparam int RANDOM_PAIRS = 1050;
	localparam int HOLD_AT      = 300;
	localparam int DRAIN_AT     = 650;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 20;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_YEAR     = (1 << YEAR_BITS) - 1;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_SOME,
		STALL_MOST
	} stall_mode_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       date_valid;
	logic       date_stall;
	date_pair_t date;
	logic       count_valid;
	logic       count_stall;
	result_t    count;

	date_span_checker spans = new();

	int burst_left = 0;
	bit hold_off_request = 1'b0;

	calendar_date_difference i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.date_valid  (date_valid),
		.date_stall  (date_stall),
		.date        (date),
		.count_valid (count_valid),
		.count_stall (count_stall),
		.count       (count)
	);

	// clock
	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic date_pair_t make_pair(int unsigned y1, int unsigned m1,
		int unsigned d1, int unsigned y2, int unsigned m2, int unsigned d2,
		bit inc);
		date_pair_t w;
		w.first_year      = year_t'(y1);
		w.first_month     = month_t'(m1);
		w.first_day       = day_t'(d1);
		w.second_year     = year_t'(y2);
		w.second_month    = month_t'(m2);
		w.second_day      = day_t'(d2);
		w.include_end_day = inc;
		return w;
	endfunction

	function automatic void random_date(input int unsigned lo, input int unsigned hi,
		output year_t y, output month_t m, output day_t d);
		y = year_t'($urandom_range(hi, lo));
		m = month_t'($urandom_range(MONTHS_PER_YEAR, 1));
		d = day_t'($urandom_range(date_span_checker::month_days(y, m), 1));
	endfunction

	// last day of a month or one past it, often in century years
	function automatic void month_end_date(output year_t y, output month_t m,
		output day_t d);
		if ($urandom_range(1, 0) == 1) begin
			y = year_t'(100 * $urandom_range(MAX_YEAR / 100, 0));
		end else begin
			y = year_t'($urandom_range(MAX_YEAR, 0));
		end
		m = month_t'($urandom_range(MONTHS_PER_YEAR, 1));
		d = day_t'(date_span_checker::month_days(y, m) + $urandom_range(1, 0));
	endfunction

	function automatic date_pair_t random_pair();
		date_pair_t  w;
		logic [63:0] raw;
		int unsigned pick;
		w = '0;
		pick = $urandom_range(99, 0);
		if (pick < 70) begin
			// well-formed dates in the stated year range
			random_date(1, 9999, w.first_year, w.first_month, w.first_day);
			if ($urandom_range(3, 0) == 0) begin
				random_date(w.first_year, w.first_year,
					w.second_year, w.second_month, w.second_day);
			end else begin
				random_date(1, 9999, w.second_year, w.second_month, w.second_day);
			end
		end else if (pick < 80) begin
			// whole year field, reaches saturation
			random_date(0, MAX_YEAR, w.first_year, w.first_month, w.first_day);
			random_date(0, MAX_YEAR, w.second_year, w.second_month, w.second_day);
		end else if (pick < 90) begin
			month_end_date(w.first_year, w.first_month, w.first_day);
			month_end_date(w.second_year, w.second_month, w.second_day);
		end else begin
			// raw noise, mostly impossible dates
			raw = {$urandom, $urandom};
			w = raw[$bits(date_pair_t)-1:0];
		end
		w.include_end_day = 1'($urandom_range(1, 0));
		return w;
	endfunction

	// offer one word, bursts of random length with gaps in between
	task automatic offer_pair(input date_pair_t w);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(8, 1);
			date_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
				: $urandom_range(12, 1);
		end
		burst_left--;
		date       <= w;
		date_valid <= 1'b1;
		do @(posedge clk); while (date_stall);
		spans.note_pair(w);
	endtask

	// stop offering until every count word is back
	task automatic drain_counts();
		date_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (spans.outstanding() != 0);
	endtask

	// output side: checks accepted words, stalls on its own pattern
	initial begin
		stall_mode_t mode;
		int          mode_left;
		int          hold_left;
		mode        = STALL_NONE;
		mode_left   = 0;
		hold_left   = 0;
		count_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (count_valid && !count_stall) begin
				spans.check_count(count);
			end
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				count_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = stall_mode_t'($urandom_range(STALL_MOST, STALL_NONE));
					mode_left = $urandom_range(96, 16);
				end
				mode_left--;
				case (mode)
					STALL_SOME: begin
						count_stall <= ($urandom_range(3, 0) == 0);
					end
					STALL_MOST: begin
						count_stall <= ($urandom_range(3, 0) != 0);
					end
					default: begin
						count_stall <= 1'b0;
					end
				endcase
			end
		end
	end

	// run limit
	initial begin
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// stimulus
	initial begin
		date_pair_t directed[$];
		arst_n     = 1'b0;
		date_valid = 1'b0;
		date       = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// widest span in the stated range, end day counted
		directed.push_back(make_pair(1, 1, 1, 9999, 12, 31, 1'b1));
		// equal dates with and without the end day
		directed.push_back(make_pair(2024, 2, 29, 2024, 2, 29, 1'b0));
		directed.push_back(make_pair(2024, 2, 29, 2024, 2, 29, 1'b1));
		// leap day of a 400 year against a century year
		directed.push_back(make_pair(2000, 2, 29, 1900, 2, 28, 1'b0));
		directed.push_back(make_pair(1900, 2, 29, 2000, 1, 1, 1'b0));
		directed.push_back(make_pair(2001, 1, 1, 2001, 2, 29, 1'b1));
		directed.push_back(make_pair(2400, 2, 29, 2100, 3, 1, 1'b0));
		directed.push_back(make_pair(2400, 2, 30, 2400, 3, 1, 1'b0));
		// year zero is a leap year
		directed.push_back(make_pair(0, 2, 29, 0, 1, 1, 1'b1));
		directed.push_back(make_pair(0, 3, 1, 4, 3, 1, 1'b0));
		// saturation, both orders
		directed.push_back(make_pair(0, 1, 1, MAX_YEAR, 12, 31, 1'b1));
		directed.push_back(make_pair(MAX_YEAR, 12, 31, 0, 1, 1, 1'b0));
		directed.push_back(make_pair(1, 1, 1, MAX_YEAR, 12, 31, 1'b0));
		// month outside the calendar
		directed.push_back(make_pair(2020, 0, 10, 2020, 1, 10, 1'b0));
		directed.push_back(make_pair(2020, 5, 10, 2020, 13, 10, 1'b1));
		directed.push_back(make_pair(2020, 15, 1, 2020, 1, 1, 1'b0));
		// day zero and day past the month end
		directed.push_back(make_pair(2020, 6, 0, 2020, 6, 1, 1'b0));
		directed.push_back(make_pair(2020, 4, 31, 2020, 5, 31, 1'b0));
		directed.push_back(make_pair(2020, 12, 31, 2020, 11, 31, 1'b1));
		// year boundary and a second date before the first
		directed.push_back(make_pair(2023, 12, 31, 2024, 1, 1, 1'b0));
		directed.push_back(make_pair(2024, 3, 1, 2024, 2, 28, 1'b1));
		// all fields zero and all fields ones
		directed.push_back(make_pair(0, 0, 0, 0, 0, 0, 1'b0));
		directed.push_back(make_pair(MAX_YEAR, 15, 31, MAX_YEAR, 15, 31, 1'b1));
		foreach (directed[i]) begin
			offer_pair(directed[i]);
		end

		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			// long output hold so the pipeline fills and stalls its input
			if (i == HOLD_AT) begin
				hold_off_request = 1'b1;
			end
			if (i == DRAIN_AT) begin
				drain_counts();
			end
			offer_pair(random_pair());
		end

		drain_counts();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (spans.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== calendar_date_difference.f =====
rtl/core/cdd_pkg.sv
rtl/core/cdd_day_number.sv
rtl/core/calendar_date_difference.sv
test/cdd_span_check_pkg.sv
test/tb_top.sv
